### src/command_line_lexer_checker_assert.svh
// assertion macros for the command line lexer checker
`ifndef COMMAND_LINE_LEXER_CHECKER_ASSERT_SVH
`define COMMAND_LINE_LEXER_CHECKER_ASSERT_SVH
`ifndef SYNTH
// checked outside reset
`define CLLC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define CLLC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLLC_ASSERT(lbl, prop, msg)
`define CLLC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### src/cllc_pkg.sv
// shared types, codes and keyword tables of the command line lexer checker
package cllc_pkg;

    localparam int MAX_TOKENS = 8;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SYNTAX   = 3'd1;
    localparam logic [2:0] ST_TOO_MANY = 3'd2;
    localparam logic [2:0] ST_UNKNOWN  = 3'd3;
    localparam logic [2:0] ST_TOO_FEW  = 3'd4;
    localparam logic [2:0] ST_INVALID  = 3'd5;
    localparam logic [2:0] ST_QUIT     = 3'd6;

    // command codes
    localparam logic [3:0] CMD_NONE     = 4'd0;
    localparam logic [3:0] CMD_PUT      = 4'd1;
    localparam logic [3:0] CMD_GET      = 4'd2;
    localparam logic [3:0] CMD_LS       = 4'd3;
    localparam logic [3:0] CMD_CD       = 4'd4;
    localparam logic [3:0] CMD_PWD      = 4'd5;
    localparam logic [3:0] CMD_MAKE_DIR = 4'd6;
    localparam logic [3:0] CMD_REMOVE   = 4'd7;
    localparam logic [3:0] CMD_EXIT     = 4'd8;

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;

    // keyword k matches command code k+1, padded to eight characters
    localparam logic [7:0] KW_TEXT [8][8] = '{
        '{"p", "u", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"g", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"l", "s", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"p", "w", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"m", "k", "d", "i", "r", 8'h00, 8'h00, 8'h00},
        '{"d", "e", "l", "e", "t", "e", 8'h00, 8'h00},
        '{"q", "u", "i", "t", 8'h00, 8'h00, 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [8] = '{3'd3, 3'd3, 3'd2, 3'd2, 3'd3, 3'd5, 3'd6, 3'd4};

    localparam logic [7:0] MODE_TEXT [8] = '{"a", "s", "c", "i", "i",
                                             8'h00, 8'h00, 8'h00};
    localparam logic [2:0] MODE_LEN = 3'd5;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] echo_byte;
        logic       is_token_text;
        logic [3:0] token_number;
        logic       token_closed;
        logic       request_done;
        logic [2:0] status_code;
        logic [3:0] command_code;
    } out_beat_t;

    // per byte token marks from the lexer
    typedef struct packed {
        logic       is_text;
        logic       closed;
        logic [3:0] token_number;
    } lex_marks_t;

    // lexer state after the current byte, for the end of line check
    typedef struct packed {
        logic [2:0] error_code;
        logic [3:0] token_count;
        logic [7:0] keyword_hits;
        logic       mode_word_hit;
        logic [3:0] arg_nonempty;
    } lex_summary_t;

endpackage

### src/command_line_lexer_checker.sv
// top level: request byte lexer and command checker
//
//  channel | signals                          | carries
//  req     | req_valid, req_ready, req_beat   | one request character and last flag
//  rsp     | rsp_valid, rsp_ready, rsp_beat   | echoed character, token marks, status
//
// one beat in, one beat out; a beat is accepted every cycle while rsp flows
// a beat goes through the input register, then the lexer step into the result register
// the lexer state is updated as a beat moves into the result register
// a stalled rsp holds the result; req_ready drops only when both registers are full
// reset clears the lexer to the start of a line, with no results pending
module command_line_lexer_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  cllc_pkg::in_beat_t   req_beat,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output cllc_pkg::out_beat_t  rsp_beat
);
    import cllc_pkg::*;

    in_beat_t     in_reg;
    logic         in_valid_reg;
    out_beat_t    out_reg, out_next;
    logic         out_valid_reg;
    logic         advance;
    logic         step;
    lex_marks_t   marks;
    lex_summary_t summary;
    logic [2:0]   status_code;
    logic [3:0]   command_code;

    assign advance   = !out_valid_reg || rsp_ready;
    assign step      = in_valid_reg && advance;
    assign req_ready = !in_valid_reg || advance;

    cllc_lexer u_lexer (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .beat    (in_reg),
        .marks   (marks),
        .summary (summary)
    );

    cllc_verify u_verify (
        .summary      (summary),
        .status_code  (status_code),
        .command_code (command_code)
    );

    always_comb
    begin
        out_next.echo_byte     = in_reg.char_byte;
        out_next.is_token_text = marks.is_text;
        out_next.token_number  = marks.token_number;
        out_next.token_closed  = marks.closed;
        out_next.request_done  = in_reg.last_byte;
        out_next.status_code   = in_reg.last_byte ? status_code : ST_OK;
        out_next.command_code  = in_reg.last_byte ? command_code : CMD_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                in_valid_reg <= req_valid;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            in_reg <= req_beat;
        end
        if (step)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_beat  = out_reg;

endmodule

### src/cllc_lexer.sv
// byte lexer: token state, keyword tracking and error capture
`include "command_line_lexer_checker_assert.svh"

module cllc_lexer (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  cllc_pkg::in_beat_t      beat,
    output cllc_pkg::lex_marks_t    marks,
    output cllc_pkg::lex_summary_t  summary
);
    import cllc_pkg::*;

    typedef enum logic [1:0] {
        MODE_BETWEEN,
        MODE_PLAIN,
        MODE_QUOTED,
        MODE_AFTER_QUOTE
    } lex_mode_t;

    lex_mode_t  mode_reg, mode_next;
    logic [3:0] count_reg, count_next;
    logic [2:0] pos_reg, pos_next;
    logic [7:0] hits_reg, hits_next;
    logic       mword_reg, mword_next;
    logic [3:0] args_reg, args_next;
    logic [2:0] err_reg, err_next;

    logic [7:0] c;
    logic       last;
    logic       delim;
    logic       quote;
    logic       take;
    logic       close;
    logic       syn;

    assign c     = beat.char_byte;
    assign last  = beat.last_byte;
    assign delim = (c == CH_SPACE) || (c == CH_NEWLINE);
    assign quote = (c == CH_QUOTE);

    // lexer transitions
    always_comb
    begin
        mode_next = mode_reg;
        take      = 1'b0;
        close     = 1'b0;
        syn       = 1'b0;
        if (err_reg == ST_OK)
        begin
            case (mode_reg)
                MODE_BETWEEN:
                begin
                    if (delim)
                    begin
                        mode_next = MODE_BETWEEN;
                    end
                    else if (quote)
                    begin
                        mode_next = MODE_QUOTED;
                        syn       = last;
                    end
                    else
                    begin
                        take      = 1'b1;
                        mode_next = MODE_PLAIN;
                        close     = last;
                    end
                end
                MODE_PLAIN:
                begin
                    if (delim)
                    begin
                        close     = 1'b1;
                        mode_next = MODE_BETWEEN;
                    end
                    else if (quote)
                    begin
                        syn = 1'b1;
                    end
                    else
                    begin
                        take  = 1'b1;
                        close = last;
                    end
                end
                MODE_QUOTED:
                begin
                    if (quote)
                    begin
                        mode_next = MODE_AFTER_QUOTE;
                        close     = last;
                    end
                    else if ((c == CH_NEWLINE) || last)
                    begin
                        syn = 1'b1;
                    end
                    else
                    begin
                        take = 1'b1;
                    end
                end
                default:
                begin
                    if (delim)
                    begin
                        close     = 1'b1;
                        mode_next = MODE_BETWEEN;
                    end
                    else
                    begin
                        syn = 1'b1;
                    end
                end
            endcase
        end
    end

    // text update first, then token close on the same byte
    always_comb
    begin
        count_next = count_reg;
        pos_next   = pos_reg;
        hits_next  = hits_reg;
        mword_next = mword_reg;
        args_next  = args_reg;
        err_next   = err_reg;
        if (take)
        begin
            if (count_reg == 4'd0)
            begin
                for (int k = 0; k < 8; k++)
                begin
                    if ((pos_reg >= KW_LEN[k]) || (KW_TEXT[k][pos_reg] != c))
                    begin
                        hits_next[k] = 1'b0;
                    end
                end
            end
            if (count_reg == 4'd3)
            begin
                if ((pos_reg >= MODE_LEN) || (MODE_TEXT[pos_reg] != c))
                begin
                    mword_next = 1'b0;
                end
            end
            if ((count_reg >= 4'd1) && (count_reg <= 4'd4))
            begin
                args_next[2'(count_reg - 4'd1)] = 1'b1;
            end
            if (pos_reg != 3'd7)
            begin
                pos_next = pos_reg + 3'd1;
            end
        end
        if (close)
        begin
            if (count_reg >= 4'(MAX_TOKENS))
            begin
                err_next = ST_TOO_MANY;
            end
            else
            begin
                if (count_reg == 4'd0)
                begin
                    for (int k = 0; k < 8; k++)
                    begin
                        if (pos_next != KW_LEN[k])
                        begin
                            hits_next[k] = 1'b0;
                        end
                    end
                end
                if ((count_reg == 4'd3) && (pos_next != MODE_LEN))
                begin
                    mword_next = 1'b0;
                end
                count_next = count_reg + 4'd1;
            end
            pos_next = 3'd0;
        end
        if (syn)
        begin
            err_next = ST_SYNTAX;
        end
    end

    assign marks.is_text      = take;
    assign marks.closed       = close;
    assign marks.token_number = count_reg;

    assign summary.error_code    = err_next;
    assign summary.token_count   = count_next;
    assign summary.keyword_hits  = hits_next;
    assign summary.mode_word_hit = mword_next;
    assign summary.arg_nonempty  = args_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_BETWEEN;
            count_reg <= 4'd0;
            pos_reg   <= 3'd0;
            hits_reg  <= 8'hff;
            mword_reg <= 1'b1;
            args_reg  <= 4'd0;
            err_reg   <= ST_OK;
        end
        else if (step)
        begin
            if (last)
            begin
                // line finished, start the next one clean
                mode_reg  <= MODE_BETWEEN;
                count_reg <= 4'd0;
                pos_reg   <= 3'd0;
                hits_reg  <= 8'hff;
                mword_reg <= 1'b1;
                args_reg  <= 4'd0;
                err_reg   <= ST_OK;
            end
            else
            begin
                mode_reg  <= mode_next;
                count_reg <= count_next;
                pos_reg   <= pos_next;
                hits_reg  <= hits_next;
                mword_reg <= mword_next;
                args_reg  <= args_next;
                err_reg   <= err_next;
            end
        end
    end

    `CLLC_ASSERT(a_count_bound, count_reg <= 4'(MAX_TOKENS), "token count past limit")
    `CLLC_ASSERT(a_pos_in_token, pos_reg != 3'd0 |-> mode_reg != MODE_BETWEEN, "stray count")
    `CLLC_ASSERT(a_count_restart, step && last |=> count_reg == 4'd0, "count not cleared")
    `CLLC_ASSERT(a_mode_restart, step && last |=> mode_reg == MODE_BETWEEN, "mode not cleared")
    `CLLC_ASSERT(a_error_sticky, err_reg != ST_OK && !last |=> $stable(err_reg), "error lost")

endmodule

### src/cllc_verify.sv
// end of line check: command decode, lexer error, argument count and mode word status
module cllc_verify (
    input  cllc_pkg::lex_summary_t summary,
    output logic [2:0]             status_code,
    output logic [3:0]             command_code
);
    import cllc_pkg::*;

    logic [3:0] hit_code;
    logic [3:0] args;

    assign args = summary.arg_nonempty;

    // lowest live keyword wins
    always_comb
    begin
        hit_code = CMD_NONE;
        for (int k = 7; k >= 0; k--)
        begin
            if (summary.keyword_hits[k])
            begin
                hit_code = 4'(k + 1);
            end
        end
    end

    always_comb
    begin
        status_code  = ST_OK;
        command_code = CMD_NONE;
        if (summary.error_code != ST_OK)
        begin
            status_code = summary.error_code;
        end
        else if ((summary.token_count == 4'd0) || (hit_code == CMD_NONE))
        begin
            status_code = ST_UNKNOWN;
        end
        else
        begin
            command_code = hit_code;
            case (hit_code)
                CMD_LS, CMD_PWD, CMD_EXIT:
                begin
                    if (args[0])
                        status_code = ST_TOO_MANY;
                    else if (hit_code == CMD_EXIT)
                        status_code = ST_QUIT;
                    else
                        status_code = ST_OK;
                end
                CMD_CD, CMD_MAKE_DIR, CMD_REMOVE:
                begin
                    if (!args[0])
                        status_code = ST_TOO_FEW;
                    else if (args[1])
                        status_code = ST_TOO_MANY;
                    else
                        status_code = ST_OK;
                end
                default:
                begin
                    if (!args[1])
                        status_code = ST_TOO_FEW;
                    else if (args[3])
                        status_code = ST_TOO_MANY;
                    else if (args[2] && !summary.mode_word_hit)
                        status_code = ST_INVALID;
                    else
                        status_code = ST_OK;
                end
            endcase
        end
    end

endmodule
